// File: hdl/udf_pkg.sv
package udf_pkg;

  typedef struct packed {
    logic load;
    logic step;
    logic pop;
    logic finish;
  } udf_cmd_t;

  typedef struct packed {
    logic done;
    logic final_step;
    logic have_out;
    logic have_out_after;
    logic last;
  } udf_stat_t;

endpackage

// File: hdl/udf_datapath.sv
module udf_datapath import udf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  input  udf_cmd_t   cmd,
  output udf_stat_t  stat,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       last_of_run,
  output logic       text_done
);

  logic [7:0]  buf_r [4];
  logic [2:0]  cnt_r;
  logic [7:0]  emit_r [4];
  logic [2:0]  ecnt_r;
  logic [1:0]  rd_r;
  logic        end_r;

  logic [7:0]  lead;
  logic [2:0]  len;
  logic [3:0]  cont;
  logic        bad;
  logic        short_seq;
  logic        wait_c;
  logic        valid_seq;
  logic [2:0]  consume;
  logic [20:0] cp;
  logic        filt;
  logic [2:0]  nemit;
  logic [2:0]  ecnt_after;
  logic [7:0]  shifted [4];
  logic [2:0]  src [4];
  logic [2:0]  ofs [4];
  logic        last_c;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    if (b < 8'h80) begin
      return 3'd1;
    end else if (b < 8'hE0) begin
      return 3'd2;
    end else if (b < 8'hF0) begin
      return 3'd3;
    end else if (b < 8'hF8) begin
      return 3'd4;
    end
    return 3'd0;
  endfunction

  function automatic logic in_range(input logic [20:0] v, input logic [20:0] lo,
                                    input logic [20:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic in_filter(input logic [20:0] v);
    return in_range(v, 21'h1F600, 21'h1F64F) || in_range(v, 21'h1F300, 21'h1F5FF) ||
           in_range(v, 21'h1F680, 21'h1F6FF) || in_range(v, 21'h1F900, 21'h1F9FF) ||
           in_range(v, 21'h1F1E0, 21'h1F1FF) || in_range(v, 21'h1FA00, 21'h1FAFF) ||
           in_range(v, 21'h02300, 21'h023FF) || in_range(v, 21'h02460, 21'h027BF) ||
           in_range(v, 21'h0FE00, 21'h0FE0F) || (v == 21'h0200D) || (v == 21'h020E3) ||
           in_range(v, 21'hE0000, 21'hE007F);
  endfunction

  always_comb begin
    lead = buf_r[0];
    len  = seq_len(lead);
    for (int i = 0; i < 4; i++) begin
      cont[i] = (buf_r[i][7:6] == 2'b10);
    end
    bad = 1'b0;
    for (int i = 1; i < 4; i++) begin
      if ((3'(i) < cnt_r) && (3'(i) < len) && !cont[i]) begin
        bad = 1'b1;
      end
    end
    short_seq = (len > 3'd1) && !bad && (cnt_r < len);
    wait_c    = short_seq && !end_r;
    valid_seq = (len > 3'd1) && !bad && !short_seq;
    consume   = valid_seq ? len : 3'd1;
    case (len)
      3'd2:    cp = {10'd0, buf_r[0][4:0], buf_r[1][5:0]};
      3'd3:    cp = {5'd0, buf_r[0][3:0], buf_r[1][5:0], buf_r[2][5:0]};
      3'd4:    cp = {buf_r[0][2:0], buf_r[1][5:0], buf_r[2][5:0], buf_r[3][5:0]};
      default: cp = 21'd0;
    endcase
    filt = in_filter(cp);
    if (len == 3'd1) begin
      nemit = 3'd1;
    end else if (valid_seq && !filt) begin
      nemit = len;
    end else begin
      nemit = 3'd0;
    end
    ecnt_after = ecnt_r + nemit;
    for (int i = 0; i < 4; i++) begin
      src[i]     = 3'(i) + consume;
      shifted[i] = buf_r[src[i][1:0]];
      ofs[i]     = 3'(i) - ecnt_r;
    end
    last_c = (ecnt_r == 3'd0) || ({1'b0, rd_r} == (ecnt_r - 3'd1));
  end

  assign stat.done           = (cnt_r == 3'd0) || wait_c;
  assign stat.final_step     = (cnt_r == consume);
  assign stat.have_out       = (ecnt_r != 3'd0) || end_r;
  assign stat.have_out_after = (ecnt_after != 3'd0) || end_r;
  assign stat.last           = last_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      ecnt_r <= 3'd0;
      rd_r   <= 2'd0;
      end_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        buf_r[cnt_r[1:0]] <= in_byte;
        cnt_r             <= cnt_r + 3'd1;
        end_r             <= in_end;
      end
      if (cmd.step) begin
        for (int i = 0; i < 4; i++) begin
          if (src[i] < 3'd4) begin
            buf_r[i] <= shifted[i];
          end
          if ((3'(i) >= ecnt_r) && (3'(i) < ecnt_after)) begin
            emit_r[i] <= buf_r[ofs[i][1:0]];
          end
        end
        cnt_r  <= cnt_r - consume;
        ecnt_r <= ecnt_after;
      end
      if (cmd.finish) begin
        ecnt_r <= 3'd0;
        rd_r   <= 2'd0;
      end else if (cmd.pop) begin
        rd_r <= rd_r + 2'd1;
      end
    end
  end

  assign has_byte    = (ecnt_r != 3'd0);
  assign out_byte    = has_byte ? emit_r[rd_r] : 8'h00;
  assign last_of_run = last_c;
  assign text_done   = last_c && end_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("buffer count out of range");
  a_ecnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> ecnt_after <= 3'd4)
    else $error("emit queue overflow");
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (cnt_r <= 3'd3) && (ecnt_r == 3'd0))
    else $error("load into a full buffer or undrained queue");
`endif

endmodule

// File: hdl/udf_ctrl.sv
module udf_ctrl import udf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  udf_stat_t stat,
  output udf_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROC,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, out_tvalid_r;

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd.load   = in_tvalid && in_tready_r;
    cmd.step   = (state_r == S_PROC) && !stat.done;
    cmd.pop    = out_tvalid_r && out_tready;
    cmd.finish = cmd.pop && stat.last;
    state_nxt  = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        if (stat.done) begin
          state_nxt = stat.have_out ? S_OUT : S_IDLE;
        end else if (stat.final_step) begin
          state_nxt = stat.have_out_after ? S_OUT : S_IDLE;
        end
      end
      S_OUT: begin
        if (cmd.finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_tready_r  <= (state_nxt == S_IDLE);
      out_tvalid_r <= (state_nxt == S_OUT);
    end
  end

endmodule

// File: hdl/utf8_emoji_filter.sv
// An accepted byte is decoded one sequence per cycle by the single decode step.
// No new byte is taken until those steps are done and every result that they
// gave has been taken at the output.
// Reset: synchronous, active low; clears the buffer count and result queue, and the
// input becomes ready in the cycle after reset is released.
module utf8_emoji_filter import udf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last_of_run
  output logic [1:0] out_tuser   // [0] has_byte, [1] text_done
);

  udf_cmd_t  cmd;
  udf_stat_t stat;
  logic      has_byte;
  logic      text_done;

  udf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  udf_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_byte     (in_tdata),
    .in_end      (in_tlast),
    .cmd         (cmd),
    .stat        (stat),
    .out_byte    (out_tdata),
    .has_byte    (has_byte),
    .last_of_run (out_tlast),
    .text_done   (text_done)
  );

  assign out_tuser = {text_done, has_byte};

`ifndef SYNTHESIS
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output sides open together");
  a_ret_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not ready after final result");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && !out_tvalid))
    else $error("accepted byte not processed");
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && out_tuser[1] && out_tdata == 8'h00))
    else $error("malformed end marker");
`endif

endmodule

// File: dv/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       run_end;
    logic       text_end;
  } filt_word_t;

  localparam int NUM_RANGES = 12;
  localparam logic [20:0] FILT_LO [NUM_RANGES] = '{
    21'h1F600, 21'h1F300, 21'h1F680, 21'h1F900, 21'h1F1E0, 21'h1FA00,
    21'h02300, 21'h02460, 21'h0FE00, 21'h0200D, 21'h020E3, 21'hE0000
  };
  localparam logic [20:0] FILT_HI [NUM_RANGES] = '{
    21'h1F64F, 21'h1F5FF, 21'h1F6FF, 21'h1F9FF, 21'h1F1FF, 21'h1FAFF,
    21'h023FF, 21'h027BF, 21'h0FE0F, 21'h0200D, 21'h020E3, 21'hE007F
  };

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;

  filt_word_t expected_words[$];
  logic [7:0] held_bytes[$];

  bit idle_on = 1'b1;
  int stall_request = 0;
  int hold_cycles = 0;
  int words_sent = 0;
  int strings_sent = 0;
  int words_checked = 0;
  int errors = 0;
  int mismatches = 0;

  utf8_emoji_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_filtered(logic [20:0] cp);
    for (int r = 0; r < NUM_RANGES; r++) begin
      if (cp >= FILT_LO[r] && cp <= FILT_HI[r]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_word(logic [7:0] b, logic eot);
    logic [7:0] work[$];
    logic [7:0] emitted[$];
    logic [7:0] lead;
    logic [20:0] cp;
    int len;
    int consume;
    int avail;
    int ne;
    bit bad;
    work = held_bytes;
    work.push_back(b);
    while (work.size() > 0) begin
      lead = work[0];
      consume = 1;
      if (lead < 8'h80) len = 1;
      else if (lead < 8'hE0) len = 2;
      else if (lead < 8'hF0) len = 3;
      else if (lead < 8'hF8) len = 4;
      else len = 0;
      if (len == 1) begin
        emitted.push_back(lead);
      end else if (len > 1) begin
        bad = 1'b0;
        avail = (work.size() < len) ? work.size() - 1 : len - 1;
        for (int i = 1; i <= avail; i++) begin
          if (work[i][7:6] != 2'b10) bad = 1'b1;
        end
        if (!bad && work.size() < len) begin
          if (!eot) break;
          bad = 1'b1;
        end
        if (!bad) begin
          consume = len;
          case (len)
            2: cp = {10'd0, work[0][4:0], work[1][5:0]};
            3: cp = {5'd0, work[0][3:0], work[1][5:0], work[2][5:0]};
            default: cp = {work[0][2:0], work[1][5:0], work[2][5:0], work[3][5:0]};
          endcase
          if (!is_filtered(cp)) begin
            for (int i = 0; i < len; i++) emitted.push_back(work[i]);
          end
        end
      end
      repeat (consume) void'(work.pop_front());
    end
    held_bytes = work;
    ne = emitted.size();
    for (int k = 0; k < ne; k++) begin
      expected_words.push_back('{emitted[k], 1'b1, k == ne - 1, (k == ne - 1) && eot});
    end
    if (eot && ne == 0) expected_words.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
  endfunction

  task automatic send_word(logic [7:0] b, logic eot);
    while (idle_on && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eot;
    @(negedge clk);
    while (!in_tready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    predict_word(b, eot);
    words_sent++;
  endtask

  task automatic send_text(logic [7:0] text[$]);
    foreach (text[i]) send_word(text[i], i == text.size() - 1);
    strings_sent++;
  endtask

  task automatic send_random_string(int nchars);
    logic [7:0] text[$];
    logic [7:0] enc [4];
    logic [20:0] cp;
    int len;
    int keep;
    int pick;
    int r;
    for (int c = 0; c < nchars; c++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        text.push_back(8'($urandom_range(1, 255)));
        continue;
      end
      if (pick < 35) begin
        cp = 21'($urandom_range(1, 127));
        len = 1;
      end else if (pick < 65) begin
        r = $urandom_range(NUM_RANGES - 1);
        case ($urandom_range(4))
          0: cp = FILT_LO[r] - 21'd1;
          1: cp = FILT_LO[r];
          2: cp = FILT_HI[r];
          3: cp = FILT_HI[r] + 21'd1;
          default: cp = 21'($urandom_range(FILT_HI[r], FILT_LO[r]));
        endcase
        len = (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
      end else begin
        len = $urandom_range(2, 4);
        cp = 21'($urandom_range(len == 2 ? 32'h7FF : len == 3 ? 32'hFFFF : 32'h1FFFFF));
      end
      case (len)
        1: enc[0] = {1'b0, cp[6:0]};
        2: begin
          enc[0] = {3'b110, cp[10:6]};
          enc[1] = {2'b10, cp[5:0]};
        end
        3: begin
          enc[0] = {4'b1110, cp[15:12]};
          enc[1] = {2'b10, cp[11:6]};
          enc[2] = {2'b10, cp[5:0]};
        end
        default: begin
          enc[0] = {5'b11110, cp[20:18]};
          enc[1] = {2'b10, cp[17:12]};
          enc[2] = {2'b10, cp[11:6]};
          enc[3] = {2'b10, cp[5:0]};
        end
      endcase
      keep = len;
      if (len > 1 && $urandom_range(9) == 0) keep = $urandom_range(1, len - 1);
      for (int i = 0; i < keep; i++) text.push_back(enc[i]);
    end
    send_text(text);
  endtask

  // Plain and accented text, a joiner, a face and a supplementary letter, bytes
  // that are always dropped, a bad follower, stray continuations, and a string
  // that ends in the middle of a sequence.
  task automatic test_directed();
    send_text('{8'h01, 8'hC3, 8'hA9, 8'hE2, 8'h80, 8'h8D});
    send_text('{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80});
    send_text('{8'hF8, 8'hFF, 8'hC3, 8'h41, 8'h80, 8'h80, 8'h7F});
    send_text('{8'hE2, 8'h82});
  endtask

  task automatic test_random_text();
    int stop_at;
    stop_at = words_sent + 40;
    while (words_sent < stop_at) send_random_string($urandom_range(1, 8));
  endtask

  task automatic test_steady_stream();
    int stop_at;
    stop_at = words_sent + 30;
    idle_on = 1'b0;
    while (words_sent < stop_at) send_random_string($urandom_range(2, 10));
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    stall_request = 300;
    hold_cycles += 300;
    repeat (4) send_random_string(6);
    idle_on = 1'b1;
  endtask

  initial begin
    int stall_left;
    forever begin
      @(posedge clk);
      if (stall_request > 0) begin
        out_tready <= 1'b0;
        stall_left = stall_request;
        stall_request = 0;
        while (stall_left > 0) begin
          @(posedge clk);
          stall_left--;
        end
      end
      out_tready <= !(idle_on && $urandom_range(99) < 31);
    end
  end

  always @(negedge clk) begin
    filt_word_t got;
    filt_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata, out_tuser[0], out_tlast, out_tuser[1]};
      words_checked++;
      if (expected_words.size() == 0) begin
        errors++;
        if (mismatches < 10) begin
          $display("Unexpected word: byte %02h has %0b last %0b done %0b",
                   got.data, got.has_byte, got.run_end, got.text_end);
        end
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (got.data !== want.data || got.has_byte !== want.has_byte ||
            got.run_end !== want.run_end || got.text_end !== want.text_end) begin
          errors++;
          if (mismatches < 10) begin
            $display("Word %0d: expected byte %02h has %0b last %0b done %0b,",
                     words_checked, want.data, want.has_byte, want.run_end,
                     want.text_end);
            $display("  got byte %02h has %0b last %0b done %0b",
                     got.data, got.has_byte, got.run_end, got.text_end);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d words still expected.", expected_words.size());
    $display("utf8_emoji_filter: mismatch");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_text();
    test_steady_stream();
    test_backpressure();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Filtered %0d bytes in %0d strings and checked %0d output words,",
             words_sent, strings_sent, words_checked);
    $display("with a %0d-cycle output hold-off and %0d failures.", hold_cycles, errors);
    if (errors == 0) begin
      $display("utf8_emoji_filter: match");
    end else begin
      $display("utf8_emoji_filter: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hdl/udf_pkg.sv
hdl/udf_datapath.sv
hdl/udf_ctrl.sv
hdl/utf8_emoji_filter.sv
dv/testbench.sv
